// ===== hdl/bao_pkg.sv =====
// Shared types, codes and constants for the binomial American option pricer.
package bao_pkg;

    localparam int MAX_STEPS_DEF = 1024;
    localparam int FRAC_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;

    localparam logic [10:0] STEP_COUNT_RST  = 11'd256;
    localparam logic [33:0] UP_FACTOR_RST   = 34'h1_0000_0000;
    localparam logic [33:0] DOWN_FACTOR_RST = 34'h1_0000_0000;
    localparam logic [32:0] WEIGHT_UP_RST   = 33'h0_8000_0000;
    localparam logic [32:0] WEIGHT_DOWN_RST = 33'h0_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT  = 3'd0,
        CFG_UP_FACTOR   = 3'd1,
        CFG_DOWN_FACTOR = 3'd2,
        CFG_WEIGHT_UP   = 3'd3,
        CFG_WEIGHT_DOWN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] spot_price;
        logic [63:0] strike_price;
        logic        is_call;
    } item_t;

    typedef struct packed {
        logic [63:0] root_value;
        logic        saturated;
    } result_t;

    typedef enum logic [1:0] {
        MOP_BASE,
        MOP_NODE,
        MOP_WUP,
        MOP_WDN
    } mul_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_B0,
        S_BMUL,
        S_BWAIT,
        S_LEAF_INIT,
        S_LEAF_WR,
        S_NP_M1,
        S_NP_W1,
        S_NP_M2,
        S_NP_W2,
        S_LV_INIT,
        S_LV_LOAD,
        S_ND_RD,
        S_ND_MA,
        S_ND_WA,
        S_ND_MB,
        S_ND_WB,
        S_ND_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    b0_write;
        logic    base_latch;
        logic    leaf_init;
        logic    leaf_write;
        logic    np_latch;
        logic    i_inc;
        logic    lv_from_n;
        logic    lv_dec;
        logic    base_rd;
        logic    lv_load;
        logic    v_rd_hi;
        logic    v_rd_lo;
        logic    ha_latch;
        logic    hb_latch;
        logic    node_write;
        logic    load_out;
        logic    mul_start;
        mul_op_t mul_op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic k_at_n;
        logic i_at_n;
        logic i_at_lv;
        logic n_zero;
        logic lv_zero;
    } status_t;

endpackage

// ===== hdl/bao_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bao_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hdl/bao_mul.sv =====
// Two-stage 64x64 fixed-point multiplier from four 32x32 partial products, saturating.
module bao_mul #(
    parameter int FRAC_BITS = bao_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] prod,
    output logic        ovf
);
    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic         v1_reg, done_reg;
    logic [63:0]  prod_reg;
    logic         ovf_reg;
    logic [127:0] full;
    logic [127:0] shifted;

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= a[31:0]  * b[31:0];
        pp_lh_reg <= a[31:0]  * b[63:32];
        pp_hl_reg <= a[63:32] * b[31:0];
        pp_hh_reg <= a[63:32] * b[63:32];
        prod_reg  <= (|shifted[127:64]) ? '1 : shifted[63:0];
        ovf_reg   <= |shifted[127:64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_comb
    begin
        full = {pp_hh_reg, pp_ll_reg}
             + {32'd0, pp_lh_reg, 32'd0}
             + {32'd0, pp_hl_reg, 32'd0};
        shifted = full >> FRAC_BITS;
    end

    assign done = done_reg;
    assign prod = prod_reg;
    assign ovf  = ovf_reg;
endmodule

// ===== hdl/bao_ctrl.sv =====
// Sequencer for leaf fill and backward induction.
module bao_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output logic             result_valid,
    input  logic             result_stall,
    input  bao_pkg::status_t sts,
    output bao_pkg::cmd_t    cmd
);
    import bao_pkg::*;

    state_t state_reg, state_next;
    logic   level_reg, level_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (item_valid) state_next = S_B0;
            S_B0:        state_next = sts.n_zero ? S_LEAF_INIT : S_BMUL;
            S_BMUL:      state_next = S_BWAIT;
            S_BWAIT:     if (sts.mul_done) state_next = sts.k_at_n ? S_LEAF_INIT : S_BMUL;
            S_LEAF_INIT: state_next = S_LEAF_WR;
            S_LEAF_WR:
            begin
                if (!sts.i_at_n)
                    state_next = S_NP_M1;
                else
                    state_next = sts.n_zero ? S_DONE : S_LV_INIT;
            end
            S_NP_M1:     state_next = S_NP_W1;
            S_NP_W1:     if (sts.mul_done) state_next = S_NP_M2;
            S_NP_M2:     state_next = S_NP_W2;
            S_NP_W2:     if (sts.mul_done) state_next = level_reg ? S_ND_RD : S_LEAF_WR;
            S_LV_INIT:   state_next = S_LV_LOAD;
            S_LV_LOAD:   state_next = S_ND_RD;
            S_ND_RD:     state_next = S_ND_MA;
            S_ND_MA:     state_next = S_ND_WA;
            S_ND_WA:     if (sts.mul_done) state_next = S_ND_MB;
            S_ND_MB:     state_next = S_ND_WB;
            S_ND_WB:     if (sts.mul_done) state_next = S_ND_WR;
            S_ND_WR:
            begin
                if (!sts.i_at_lv)
                    state_next = S_NP_M1;
                else
                    state_next = sts.lv_zero ? S_DONE : S_LV_INIT;
            end
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = MOP_BASE;
        item_stall     = (state_reg != S_IDLE);
        level_next     = level_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            S_IDLE:      cmd.load_item = item_valid;
            S_B0:        cmd.b0_write = 1'b1;
            S_BMUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_BASE;
            end
            S_BWAIT:     cmd.base_latch = sts.mul_done;
            S_LEAF_INIT:
            begin
                cmd.leaf_init = 1'b1;
                level_next    = 1'b0;
            end
            S_LEAF_WR:
            begin
                cmd.leaf_write = 1'b1;
                cmd.lv_from_n  = sts.i_at_n && !sts.n_zero;
            end
            S_NP_M1, S_NP_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_NODE;
            end
            S_NP_W1:     cmd.np_latch = sts.mul_done;
            S_NP_W2:
            begin
                cmd.np_latch = sts.mul_done;
                cmd.i_inc    = sts.mul_done;
            end
            S_LV_INIT:
            begin
                cmd.base_rd = 1'b1;
                level_next  = 1'b1;
            end
            S_LV_LOAD:   cmd.lv_load = 1'b1;
            S_ND_RD:     cmd.v_rd_hi = 1'b1;
            S_ND_MA:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_WUP;
                cmd.v_rd_lo   = 1'b1;
            end
            S_ND_WA:     cmd.ha_latch = sts.mul_done;
            S_ND_MB:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = MOP_WDN;
            end
            S_ND_WB:     cmd.hb_latch = sts.mul_done;
            S_ND_WR:
            begin
                cmd.node_write = 1'b1;
                cmd.lv_dec     = sts.i_at_lv && !sts.lv_zero;
            end
            S_DONE:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:     cmd = '0;
        endcase
    end

    assign result_valid = out_valid_reg;
endmodule

// ===== hdl/bao_dp.sv =====
// Datapath: counters, node price chain, shared multiplier and the two tree memories.
module bao_dp #(
    parameter int MAX_STEPS = bao_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = bao_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bao_pkg::item_t   item,
    input  logic [10:0]      step_count,
    input  logic [33:0]      up_factor,
    input  logic [33:0]      down_factor,
    input  logic [32:0]      weight_up,
    input  logic [32:0]      weight_down,
    input  bao_pkg::cmd_t    cmd,
    output bao_pkg::status_t sts,
    output bao_pkg::result_t result
);
    import bao_pkg::*;

    localparam int DEPTH = MAX_STEPS + 1;
    localparam int IDX_W = $clog2(DEPTH);

    logic [63:0]      p_reg, np_reg, strike_reg, ha_reg, hb_reg, res_reg, out_price_reg;
    logic             call_reg, out_sat_reg, sat_reg;
    logic [IDX_W-1:0] n_reg, k_reg, i_reg, lv_reg;

    logic [63:0]      mul_a, mul_b, mul_prod;
    logic             mul_done, mul_ovf;
    logic [63:0]      base_rd_data, v_rd_data;
    logic             base_we, v_we, v_re;
    logic [63:0]      base_wr_data, v_wr_data;
    logic [IDX_W-1:0] v_rd_addr;
    logic [64:0]      held_sum;
    logic [63:0]      held, pay, node_val;
    logic [IDX_W-1:0] n_in;

    function automatic logic [63:0] payoff(input logic [63:0] s, input logic [63:0] k,
                                           input logic call);
        logic [63:0] r;
        r = '0;
        if (call)
        begin
            if (s > k) r = s - k;
        end
        else
        begin
            if (k > s) r = k - s;
        end
        return r;
    endfunction

    always_comb
    begin
        if (32'(step_count) > 32'(MAX_STEPS))
            n_in = IDX_W'(MAX_STEPS);
        else
            n_in = IDX_W'(step_count);
    end

    always_comb
    begin
        case (cmd.mul_op)
            MOP_BASE:
            begin
                mul_a = p_reg;
                mul_b = {30'd0, down_factor};
            end
            MOP_NODE:
            begin
                mul_a = np_reg;
                mul_b = {30'd0, up_factor};
            end
            MOP_WUP:
            begin
                mul_a = {31'd0, weight_up};
                mul_b = v_rd_data;
            end
            MOP_WDN:
            begin
                mul_a = {31'd0, weight_down};
                mul_b = v_rd_data;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bao_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod),
        .ovf   (mul_ovf)
    );

    always_comb
    begin
        pay      = payoff(np_reg, strike_reg, call_reg);
        held_sum = {1'b0, ha_reg} + {1'b0, hb_reg};
        held     = held_sum[64] ? '1 : held_sum[63:0];
        node_val = (held > pay) ? held : pay;
    end

    assign base_we      = cmd.b0_write || cmd.base_latch;
    assign base_wr_data = cmd.b0_write ? p_reg : mul_prod;
    assign v_we         = cmd.leaf_write || cmd.node_write;
    assign v_wr_data    = cmd.leaf_write ? pay : node_val;
    assign v_re         = cmd.v_rd_hi || cmd.v_rd_lo;
    assign v_rd_addr    = cmd.v_rd_hi ? i_reg + IDX_W'(1) : i_reg;

    bao_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_base_ram (
        .clk     (clk),
        .wr_en   (base_we),
        .wr_addr (k_reg),
        .wr_data (base_wr_data),
        .rd_en   (cmd.base_rd),
        .rd_addr (lv_reg),
        .rd_data (base_rd_data)
    );

    bao_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_node_ram (
        .clk     (clk),
        .wr_en   (v_we),
        .wr_addr (i_reg),
        .wr_data (v_wr_data),
        .rd_en   (v_re),
        .rd_addr (v_rd_addr),
        .rd_data (v_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            p_reg      <= item.spot_price;
            strike_reg <= item.strike_price;
            call_reg   <= item.is_call;
            n_reg      <= n_in;
        end
        if (cmd.base_latch)
            p_reg <= mul_prod;
        if (cmd.load_item)
            k_reg <= '0;
        else if (cmd.b0_write || cmd.base_latch)
            k_reg <= k_reg + IDX_W'(1);
        if (cmd.leaf_init)
            np_reg <= p_reg;
        else if (cmd.lv_load)
            np_reg <= base_rd_data;
        else if (cmd.np_latch)
            np_reg <= mul_prod;
        if (cmd.leaf_init || cmd.lv_load)
            i_reg <= '0;
        else if (cmd.i_inc)
            i_reg <= i_reg + IDX_W'(1);
        if (cmd.lv_from_n)
            lv_reg <= n_reg - IDX_W'(1);
        else if (cmd.lv_dec)
            lv_reg <= lv_reg - IDX_W'(1);
        if (cmd.ha_latch)
            ha_reg <= mul_prod;
        if (cmd.hb_latch)
            hb_reg <= mul_prod;
        if (cmd.leaf_write)
            res_reg <= pay;
        else if (cmd.node_write)
            res_reg <= node_val;
        if (cmd.load_out)
        begin
            out_price_reg <= res_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            sat_reg <= 1'b0;
        end
        else if ((cmd.base_latch || cmd.np_latch || cmd.ha_latch || cmd.hb_latch) && mul_ovf)
        begin
            sat_reg <= 1'b1;
        end
        else if (cmd.node_write && held_sum[64])
        begin
            sat_reg <= 1'b1;
        end
    end

    always_comb
    begin
        sts.mul_done = mul_done;
        sts.k_at_n   = (k_reg == n_reg);
        sts.i_at_n   = (i_reg == n_reg);
        sts.i_at_lv  = (i_reg == lv_reg);
        sts.n_zero   = (n_reg == '0);
        sts.lv_zero  = (lv_reg == '0);
    end

    assign result.root_value = out_price_reg;
    assign result.saturated  = out_sat_reg;
endmodule

// ===== hdl/binomial_american_option_pricer.sv =====
// Top level of the CRR binomial American option pricer.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes step_count,
//   up_factor, down_factor, weight_up, weight_down; cfg_ready is always high.
//   Write configuration only while no item is in flight.
//   item channel (item_valid/item_stall) takes spot, strike and call/put.
//   result channel (result_valid/result_stall) returns the root value and a
//   saturation flag, one result per item.
// Timing: one item at a time. With n = min(step_count, MAX_STEPS) steps, each
//   item is priced on the shared two-stage multiplier, which computes four
//   products per tree node, one after another.
// item_stall is high from acceptance until the result is placed in the output
//   register; a new item can be taken while that result still waits.
// A stalled result holds; the block finishes the next item and then waits.
// Reset clears control and loads the default configuration registers; the
//   tree memories need no clearing.
module binomial_american_option_pricer #(
    parameter int MAX_STEPS = bao_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = bao_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  bao_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output bao_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bao_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bao_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bao_pkg::*;

    logic [10:0] step_count_reg;
    logic [33:0] up_factor_reg, down_factor_reg;
    logic [32:0] weight_up_reg, weight_down_reg;
    cmd_t        cmd;
    status_t     sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg  <= STEP_COUNT_RST;
            up_factor_reg   <= UP_FACTOR_RST;
            down_factor_reg <= DOWN_FACTOR_RST;
            weight_up_reg   <= WEIGHT_UP_RST;
            weight_down_reg <= WEIGHT_DOWN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_COUNT:  step_count_reg  <= cfg_data[10:0];
                CFG_UP_FACTOR:   up_factor_reg   <= cfg_data[33:0];
                CFG_DOWN_FACTOR: down_factor_reg <= cfg_data[33:0];
                CFG_WEIGHT_UP:   weight_up_reg   <= cfg_data[32:0];
                CFG_WEIGHT_DOWN: weight_down_reg <= cfg_data[32:0];
                default:         step_count_reg  <= step_count_reg;
            endcase
        end
    end

    bao_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    bao_dp #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .step_count  (step_count_reg),
        .up_factor   (up_factor_reg),
        .down_factor (down_factor_reg),
        .weight_up   (weight_up_reg),
        .weight_down (weight_down_reg),
        .cmd         (cmd),
        .sts         (sts),
        .result      (result)
    );
endmodule
